// ----- src/rms_pkg.sv -----
// Package: shared types and constants for row median subtraction.
`timescale 1ns / 1ps
`default_nettype none
package rms_pkg;
	localparam int unsigned SUM_W = 32;
	localparam int unsigned CNT_W = 24;
	localparam int unsigned OUT_W = 64;
	localparam int unsigned IDX_W = 10;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_FETCH = 1'b1
	} op_t;

	typedef struct packed {
		logic             op;
		logic [SUM_W-1:0] bin_sum;
		logic [CNT_W-1:0] bin_count;
		logic             row_end;
	} in_word_t;

	typedef struct packed {
		logic [OUT_W-1:0] adjusted_sum;
		logic [IDX_W-1:0] bin_index;
		logic             final_bin;
		logic             median_applied;
	} out_word_t;
endpackage
`default_nettype wire

// ----- src/rms_if.sv -----
// Interfaces: valid/ready channels for input and result words.
`timescale 1ns / 1ps
`default_nettype none
interface rms_in_if import rms_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rms_out_if import rms_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/rms_div.sv -----
// Divider: restoring division, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rms_div import rms_pkg::*; #(
	parameter int unsigned NUM_W = 48,
	parameter int unsigned DEN_W = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic [NUM_W-1:0]      quot
);
	localparam int unsigned CW = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	// Shift next numerator bit into remainder and trial subtract.
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy  <= 1'b0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= CW'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy <= 1'b0;
		end
	end

	// Remainder stays below the divisor, so DEN_W bits hold it.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quot  <= '0;
		end else if (busy) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				quot  <= {quot[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quot  <= {quot[NUM_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/row_median_subtract.sv -----
// Top level: row load, radix median selection and baseline subtraction.
// Usage:
//  - in_ch carries load words (op=0: bin_sum, bin_count, row_end) and fetch
//    words (op=1). out_ch returns one result word per fetch while a ready row has unfetched bins.
//  - min_count is written via cfg_we/cfg_data while idle.
//  - A load of a qualifying bin runs the divider; other loads skip it.
//  - At row end a bitwise radix select runs one pass per ratio bit over the
//    stored ratios of the qualifying bins.
//  - A fetch reads the stored bin, multiplies it by the median and saturates
//    the difference; the word reaches the output register through ST_F_RD,
//    ST_F_MUL and ST_F_ADJ, and no fetch is taken until it leaves ST_OUT.
//  - in_ch.ready is low while an item is in progress; the result register
//    holds while out_ch.ready is low and no new word is taken meanwhile.
//  - Reset clears pointers, the median and the ready-row flag and sets
//    min_count to 100; stores stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module row_median_subtract import rms_pkg::*; #(
	parameter int unsigned ROW_LEN   = 1024,
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	rms_in_if.sink                in_ch,
	rms_out_if.source             out_ch,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_data
);
	localparam int unsigned AW   = $clog2(ROW_LEN);
	localparam int unsigned PW   = $clog2(ROW_LEN + 1);
	localparam int unsigned NUMW = SUM_W + FRAC_BITS;
	localparam int unsigned RW   = NUMW;
	localparam int unsigned BW   = $clog2(RW);
	localparam int unsigned PRW  = RW + CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD_DIV, ST_LOAD_WAIT, ST_SEL_RD, ST_SEL_SCAN,
		ST_SEL_BIT, ST_F_RD, ST_F_MUL, ST_F_ADJ, ST_OUT
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] min_count_q;
	logic [PW-1:0]    qual_q, load_q, fetch_q;
	logic [RW-1:0]    median_q;
	logic             row_ready_q;
	logic [BW-1:0]    bit_q;
	logic [PW-1:0]    scan_q, zeros_q;
	logic [PW-1:0]    rank_q;
	logic [RW-1:0]    prefix_q;
	logic             last_q;

	// Bin and ratio stores.
	logic [SUM_W-1:0] sum_mem [ROW_LEN];
	logic [CNT_W-1:0] cnt_mem [ROW_LEN];
	logic [RW-1:0]    ratio_mem [ROW_LEN];
	logic [SUM_W-1:0] sum_rd_q;
	logic [CNT_W-1:0] cnt_rd_q;
	logic [RW-1:0]    ratio_rd_q;
	logic             rd_valid_q;

	logic [PRW-1:0]   prod_s1;
	logic [NUMW-1:0]  a_s1;
	out_word_t        out_q;

	logic             div_start;
	logic             div_busy;
	logic [NUMW-1:0]  div_quot;
	logic [SUM_W-1:0] ld_sum_q;
	logic [CNT_W-1:0] ld_cnt_q;
	logic [AW-1:0]    ld_slot_q;
	logic             qualifies;
	logic [PW-1:0]    ld_ptr;
	logic [PW-1:0]    ld_qual;

	// A ready row restarts on the next load.
	assign ld_ptr  = row_ready_q ? '0 : load_q;
	assign ld_qual = row_ready_q ? '0 : qual_q;
	assign qualifies = (in_ch.data.bin_count != '0) &&
		(in_ch.data.bin_count >= min_count_q);

	assign div_start = (state_q == ST_LOAD_DIV);

	rms_div #(.NUM_W(NUMW), .DEN_W(CNT_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({ld_sum_q, FRAC_BITS'(0)}),
		.den    (ld_cnt_q),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.data  = out_q;

	// Saturating subtract of median*count from the shifted sum.
	logic [PRW-1:0]   diff_w;
	logic [OUT_W-1:0] adj_w;
	always_comb begin
		diff_w = prod_s1 - PRW'(a_s1);
		if (prod_s1 <= PRW'(a_s1))
			adj_w = OUT_W'(a_s1) - OUT_W'(prod_s1);
		else if (diff_w >= PRW'({1'b1, 63'b0}))
			adj_w = {1'b1, 63'b0};
		else
			adj_w = '0 - OUT_W'(diff_w);
	end

	// Store writes and registered reads.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid && in_ch.data.op == OP_LOAD &&
			ld_ptr < PW'(ROW_LEN)) begin
			sum_mem[ld_ptr[AW-1:0]] <= in_ch.data.bin_sum;
			cnt_mem[ld_ptr[AW-1:0]] <= in_ch.data.bin_count;
		end
		if (state_q == ST_LOAD_WAIT && !div_busy)
			ratio_mem[ld_slot_q] <= div_quot;
		ratio_rd_q <= ratio_mem[scan_q[AW-1:0]];
		sum_rd_q   <= sum_mem[fetch_q[AW-1:0]];
		cnt_rd_q   <= cnt_mem[fetch_q[AW-1:0]];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			min_count_q <= CNT_W'(100);
			qual_q      <= '0;
			load_q      <= '0;
			fetch_q     <= '0;
			median_q    <= '0;
			row_ready_q <= 1'b0;
			bit_q       <= '0;
			scan_q      <= '0;
			zeros_q     <= '0;
			rank_q      <= '0;
			prefix_q    <= '0;
			last_q      <= 1'b0;
			rd_valid_q  <= 1'b0;
			ld_slot_q   <= '0;
		end else begin
			if (cfg_we) min_count_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.data.op == OP_LOAD) begin
						ld_sum_q <= in_ch.data.bin_sum;
						ld_cnt_q <= in_ch.data.bin_count;
						if (row_ready_q) begin
							row_ready_q <= 1'b0;
							fetch_q     <= '0;
						end
						if (ld_ptr < PW'(ROW_LEN)) begin
							load_q <= ld_ptr + 1'b1;
							last_q <= in_ch.data.row_end ||
								(ld_ptr + 1'b1 >= PW'(ROW_LEN));
							ld_slot_q <= ld_qual[AW-1:0];
							if (qualifies && ld_qual < PW'(ROW_LEN)) begin
								qual_q  <= ld_qual + 1'b1;
								state_q <= ST_LOAD_DIV;
							end else begin
								qual_q  <= ld_qual;
								state_q <= ST_LOAD_WAIT;
							end
						end else begin
							load_q <= ld_ptr;
							qual_q <= ld_qual;
						end
					end else if (in_ch.valid) begin
						if (row_ready_q && fetch_q < load_q)
							state_q <= ST_F_RD;
					end
				end
				ST_LOAD_DIV: state_q <= ST_LOAD_WAIT;
				ST_LOAD_WAIT: begin
					// Ratio is written when the divider goes idle.
					if (!div_busy) begin
						if (last_q) begin
							last_q      <= 1'b0;
							row_ready_q <= 1'b1;
							fetch_q     <= '0;
							median_q    <= '0;
							if (qual_q == '0) begin
								state_q <= ST_IDLE;
							end else begin
								bit_q    <= BW'(RW - 1);
								rank_q   <= qual_q >> 1;
								prefix_q <= '0;
								scan_q   <= '0;
								zeros_q  <= '0;
								state_q  <= ST_SEL_RD;
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				// One pass per bit: count matching ratios with a zero there.
				ST_SEL_RD: begin
					rd_valid_q <= 1'b1;
					scan_q     <= scan_q + 1'b1;
					state_q    <= ST_SEL_SCAN;
				end
				ST_SEL_SCAN: begin
					if (rd_valid_q &&
						(((ratio_rd_q ^ prefix_q) >> bit_q) >> 1) == '0 &&
						!ratio_rd_q[bit_q])
						zeros_q <= zeros_q + 1'b1;
					if (scan_q < qual_q) begin
						rd_valid_q <= 1'b1;
						scan_q     <= scan_q + 1'b1;
					end else begin
						rd_valid_q <= 1'b0;
						if (!rd_valid_q)
							state_q <= ST_SEL_BIT;
					end
				end
				ST_SEL_BIT: begin
					if (rank_q >= zeros_q) begin
						prefix_q[bit_q] <= 1'b1;
						rank_q <= rank_q - zeros_q;
					end
					zeros_q <= '0;
					scan_q  <= '0;
					if (bit_q == '0) begin
						median_q <= (rank_q >= zeros_q) ? (prefix_q | RW'(1)) : prefix_q;
						state_q  <= ST_IDLE;
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= ST_SEL_RD;
					end
				end
				ST_F_RD: state_q <= ST_F_MUL;
				ST_F_MUL: begin
					prod_s1 <= PRW'(median_q) * PRW'(cnt_rd_q);
					a_s1    <= {sum_rd_q, FRAC_BITS'(0)};
					state_q <= ST_F_ADJ;
				end
				ST_F_ADJ: begin
					out_q.adjusted_sum   <= (qual_q != '0) ? adj_w : OUT_W'(a_s1);
					out_q.bin_index      <= IDX_W'(fetch_q);
					out_q.final_bin      <= (fetch_q + 1'b1 == load_q);
					out_q.median_applied <= (qual_q != '0);
					fetch_q              <= fetch_q + 1'b1;
					state_q              <= ST_OUT;
				end
				ST_OUT: if (out_ch.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks.
	a_fetch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_q <= load_q) else $error("fetch pointer beyond loaded bins");
	a_qual_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qual_q <= load_q) else $error("more qualified bins than loaded");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_q))
		else $error("result word changed while stalled");
	a_busy_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken with result pending");
endmodule
`default_nettype wire

// ----- dv/row_median_subtract_tb.sv -----
// Testbench: directed and random load/fetch checks of row median subtraction.
`timescale 1ns / 1ps
module row_median_subtract_tb;
	import rms_pkg::*;

	localparam int ROW_MAX = 1024;
	localparam int FRAC = 16;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_data;

	rms_in_if in_ch ();
	rms_out_if out_ch ();

	row_median_subtract #(.ROW_LEN(ROW_MAX), .FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	// Predicted state of the block
	logic [SUM_W-1:0] bin_sums [ROW_MAX];
	logic [CNT_W-1:0] bin_counts [ROW_MAX];
	logic [47:0] ratio_list [$];
	logic [47:0] row_median;
	logic [CNT_W-1:0] min_count;
	int load_ptr;
	int fetch_ptr;
	bit row_ready;
	int last_qualified;

	out_word_t adjusted_q [$];
	int errors = 0;
	int tx_idle_pct;
	int rx_idle_pct;
	int word_total;
	int row_len;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Saturated sum*2^16 - median*count
	function automatic logic [63:0] baseline_adjust(logic [SUM_W-1:0] s, logic [CNT_W-1:0] c);
		logic [127:0] a;
		logic [127:0] b;
		a = 128'(s) << FRAC;
		b = 128'(row_median) * 128'(c);
		if (a >= b)
			return 64'(a - b);
		if ((b - a) >= (128'd1 << 63))
			return 64'h8000_0000_0000_0000;
		return 64'(128'd0 - (b - a));
	endfunction

	// Advance the predicted state by one accepted word
	task automatic predict_baseline(in_word_t w);
		logic [47:0] sorted [$];
		out_word_t r;
		if (w.op == OP_LOAD) begin
			if (row_ready) begin
				row_ready = 0;
				load_ptr = 0;
				fetch_ptr = 0;
				ratio_list.delete();
			end
			if (load_ptr >= ROW_MAX)
				return;
			bin_sums[load_ptr] = w.bin_sum;
			bin_counts[load_ptr] = w.bin_count;
			if (w.bin_count != 0 && w.bin_count >= min_count)
				ratio_list.push_back(48'((64'(w.bin_sum) << FRAC) / 64'(w.bin_count)));
			load_ptr++;
			if (w.row_end || load_ptr >= ROW_MAX) begin
				sorted = ratio_list;
				sorted.sort();
				row_median = (sorted.size() == 0) ? 48'd0 : sorted[sorted.size() / 2];
				last_qualified = sorted.size();
				fetch_ptr = 0;
				row_ready = 1;
			end
			return;
		end
		if (!row_ready || fetch_ptr >= load_ptr)
			return;
		r.median_applied = ratio_list.size() != 0;
		r.adjusted_sum = r.median_applied ? baseline_adjust(bin_sums[fetch_ptr], bin_counts[fetch_ptr])
			: 64'(bin_sums[fetch_ptr]) << FRAC;
		r.bin_index = IDX_W'(fetch_ptr);
		r.final_bin = (fetch_ptr + 1 == load_ptr);
		adjusted_q.push_back(r);
		fetch_ptr++;
	endtask

	// Send one word, sometimes with a random gap before it
	task automatic send_word(in_word_t w);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		do @(posedge clk); while (!in_ch.ready);
		predict_baseline(w);
		word_total++;
	endtask

	task automatic send_load(logic [SUM_W-1:0] s, logic [CNT_W-1:0] c, logic last);
		in_word_t w;
		w.op = OP_LOAD;
		w.bin_sum = s;
		w.bin_count = c;
		w.row_end = last;
		send_word(w);
	endtask

	// Fetch with random content in the ignored fields
	task automatic send_fetch();
		in_word_t w;
		w.op = OP_FETCH;
		w.bin_sum = $urandom;
		w.bin_count = CNT_W'($urandom);
		w.row_end = 1'($urandom_range(1));
		send_word(w);
	endtask

	// Drain outstanding results and let the median search finish
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (adjusted_q.size() != 0) @(posedge clk);
		repeat (48 * (last_qualified + 2) + 150) @(posedge clk);
	endtask

	task automatic write_min_count(logic [CNT_W-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		min_count = v;
	endtask

	task automatic test_directed();
		// Fetch before any row exists
		send_fetch();
		send_load(32'd0, 24'd0, 1'b0);
		send_load(32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0);
		send_load(32'd1000, 24'd100, 1'b0);
		send_load(32'd5000, 24'd200, 1'b0);
		send_load(32'd0, 24'd100, 1'b0);
		send_load(32'hFFFF_FFFF, 24'd100, 1'b1);
		repeat (3) send_fetch();
		// New row drops the rest; no bin qualifies
		send_load(32'hFFFF_FFFF, 24'd0, 1'b1);
		repeat (2) send_fetch();
		write_min_count(24'd0);
		// Zero count never qualifies even with a zero threshold
		send_load(32'd77, 24'd0, 1'b0);
		send_load(32'd12345, 24'd1, 1'b1);
		repeat (3) send_fetch();
		write_min_count(24'd1);
		// Huge median against a huge count saturates low
		send_load(32'hFFFF_FFFF, 24'd1, 1'b0);
		send_load(32'hFFFF_FFFF, 24'd1, 1'b0);
		send_load(32'd0, 24'hFF_FFFF, 1'b1);
		repeat (3) send_fetch();
	endtask

	// Full-length row without row_end at the largest threshold
	task automatic test_long_row();
		write_min_count(24'hFF_FFFF);
		for (int i = 0; i < ROW_MAX; i++)
			send_load($urandom, (i % 7 == 0) ? 24'hFF_FFFF : CNT_W'($urandom_range(500)), 1'b0);
		repeat (8) send_fetch();
	endtask

	task automatic test_random(int tx, int rx, logic [CNT_W-1:0] thr, int n);
		int c;
		int k;
		int lim;
		logic [SUM_W-1:0] s;
		write_min_count(thr);
		tx_idle_pct = tx;
		rx_idle_pct = rx;
		lim = word_total + n;
		row_len = 0;
		while (word_total < lim) begin
			if ($urandom_range(9) == 0)
				send_fetch();
			k = $urandom_range(10, 1);
			for (int i = 0; i < k; i++) begin
				case ($urandom_range(4))
					0: c = 0;
					1: c = int'(min_count) + $urandom_range(2) - 1;
					2: c = $urandom & 24'hFF_FFFF;
					3: c = $urandom_range(300, 1);
					default: c = 24'hFF_FFFF;
				endcase
				if (c < 0) c = 0;
				if (c > 24'hFF_FFFF) c = 24'hFF_FFFF;
				case ($urandom_range(5))
					0: s = 32'd0;
					1: s = 32'hFFFF_FFFF;
					2: s = $urandom_range(1000);
					default: s = $urandom;
				endcase
				row_len++;
				// Leave some rows open so the next run of bins extends them
				send_load(s, CNT_W'(c), (i == k - 1 && $urandom_range(9) != 0) || row_len >= 20);
				if (row_ready) row_len = 0;
			end
			k = $urandom_range(load_ptr + 1);
			repeat (k) send_fetch();
		end
		in_ch.valid <= 1'b0;
	endtask

	// Receiver stalls
	always @(posedge clk)
		out_ch.ready <= $urandom_range(99) >= rx_idle_pct;

	// Check each result word against the oldest prediction
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (adjusted_q.size() == 0) begin
				$error("result with nothing expected: %h", out_ch.data);
				errors++;
			end else begin
				e = adjusted_q.pop_front();
				if (out_ch.data.adjusted_sum !== e.adjusted_sum) begin
					$error("adjusted_sum expected %h actual %h", e.adjusted_sum,
						out_ch.data.adjusted_sum);
					errors++;
				end
				if (out_ch.data.bin_index !== e.bin_index) begin
					$error("bin_index expected %0d actual %0d", e.bin_index, out_ch.data.bin_index);
					errors++;
				end
				if (out_ch.data.final_bin !== e.final_bin) begin
					$error("final_bin expected %0d actual %0d", e.final_bin, out_ch.data.final_bin);
					errors++;
				end
				if (out_ch.data.median_applied !== e.median_applied) begin
					$error("median_applied expected %0d actual %0d", e.median_applied,
						out_ch.data.median_applied);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		word_total = 0;
		min_count = 24'd100;
		load_ptr = 0;
		fetch_ptr = 0;
		row_ready = 0;
		row_median = '0;
		last_qualified = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_row();
		test_random(10, 81, 24'd100, 130);
		test_random(81, 10, 24'd0, 130);
		test_random(0, 0, CNT_W'($urandom_range(5000, 1)), 130);
		wait_idle();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Hold a hard limit on run length
	initial begin
		#30ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
